// File: src/lruc_pkg.sv
// Shared widths, register codes, reset values and types for the LRU entry cache.
package lruc_pkg;

  localparam int KEY_W = 32;
  localparam int TIME_W = 32;
  localparam int PIX_W = 24;
  localparam int CNT_CFG_W = 4;
  localparam int SLOT_W = 3;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int DEF_ENTRIES = 8;

  // Register codes, taken from the word-address bit of paddr
  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_MAX_PIX = 1'b1;

  localparam logic [CNT_CFG_W-1:0] RST_ENTRIES = 4'd8;
  localparam logic [PIX_W-1:0] RST_MAX_PIX = 24'd4096;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] entries_in_use;
    logic [PIX_W-1:0]     max_pixels;
  } lruc_cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] used_at;
  } lruc_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } lruc_state_t;

endpackage

// File: src/lru_validated_entry_cache.sv
// Small fully associative cache with stamp validation and LRU replacement. A request
// takes one pass over the slots in use: the entry memory is read one slot per cycle
// through its registered read port, and a transaction holds the input stalled from
// acceptance until its result is issued. The pass covers n slots, n being the active
// slot count (min of entries_in_use and ENTRIES), none with the cache disabled; a fresh
// hit ends the pass early, and the stall lasts longer while the previous result still
// waits. A new request is thus taken only after the last one has finished its pass.
// One result is produced per request; the next request is taken while a result still
// waits to be taken.
module lru_validated_entry_cache #(
  parameter int ENTRIES = lruc_pkg::DEF_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lruc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lruc_pkg::DATA_W-1:0]  pwdata,
  output logic [lruc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lruc_pkg::KEY_W-1:0]   key,
  input  logic [lruc_pkg::TIME_W-1:0]  source_stamp,
  input  logic                         source_present,
  input  logic [lruc_pkg::TIME_W-1:0]  now,
  input  logic                         load_ok,
  input  logic [lruc_pkg::PIX_W-1:0]   item_pixels,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic [lruc_pkg::SLOT_W-1:0]  slot,
  output logic                         stale_dropped,
  output logic                         stored,
  output logic                         evicted
);
  import lruc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  lruc_cfg_t   cfg;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  lruc_entry_t mem_rdata, mem_wdata;
  logic        mem_we;

  lruc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lruc_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk   (clk),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  lruc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .key            (key),
    .source_stamp   (source_stamp),
    .source_present (source_present),
    .now            (now),
    .load_ok        (load_ok),
    .item_pixels    (item_pixels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .slot           (slot),
    .stale_dropped  (stale_dropped),
    .stored         (stored),
    .evicted        (evicted),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata)
  );

endmodule

// File: src/lruc_mem.sv
// Entry store: key, stamp and last-use time per slot, one write and one registered read port.
module lruc_mem #(
  parameter int ENTRIES = lruc_pkg::DEF_ENTRIES,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic [IDX_W-1:0]    raddr,
  output lruc_pkg::lruc_entry_t rdata,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  lruc_pkg::lruc_entry_t wdata
);
  import lruc_pkg::*;

  lruc_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/lruc_cfg_regs.sv
// APB-style configuration registers: slot count in use and size limit.
module lruc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lruc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lruc_pkg::DATA_W-1:0]  pwdata,
  output logic [lruc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output lruc_pkg::lruc_cfg_t          cfg
);
  import lruc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entries_in_use <= RST_ENTRIES;
      cfg.max_pixels <= RST_MAX_PIX;
    end else if (wr_en) begin
      unique case (paddr[ADDR_W-1])
        REG_ENTRIES: cfg.entries_in_use <= pwdata[CNT_CFG_W-1:0];
        REG_MAX_PIX: cfg.max_pixels <= pwdata[PIX_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_ENTRIES: prdata = DATA_W'(cfg.entries_in_use);
      REG_MAX_PIX: prdata = DATA_W'(cfg.max_pixels);
    endcase
  end

endmodule

// File: src/lruc_ctrl.sv
// Lookup and placement sequencer: one pass over the slots, then hit refresh, fill, or no write.
module lruc_ctrl #(
  parameter int ENTRIES = lruc_pkg::DEF_ENTRIES,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lruc_pkg::lruc_cfg_t           cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lruc_pkg::KEY_W-1:0]    key,
  input  logic [lruc_pkg::TIME_W-1:0]   source_stamp,
  input  logic                          source_present,
  input  logic [lruc_pkg::TIME_W-1:0]   now,
  input  logic                          load_ok,
  input  logic [lruc_pkg::PIX_W-1:0]    item_pixels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [lruc_pkg::SLOT_W-1:0]   slot,
  output logic                          stale_dropped,
  output logic                          stored,
  output logic                          evicted,
  output logic [IDX_W-1:0]              mem_raddr,
  input  lruc_pkg::lruc_entry_t         mem_rdata,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output lruc_pkg::lruc_entry_t         mem_wdata
);
  import lruc_pkg::*;

  lruc_state_t st, st_next;

  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   rd_idx;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_idx;

  logic [KEY_W-1:0]  req_key;
  logic [TIME_W-1:0] req_stamp;
  logic              req_present;
  logic [TIME_W-1:0] req_now;
  logic              req_load_ok;
  logic [PIX_W-1:0]  req_pixels;

  logic              hit_f;
  logic [IDX_W-1:0]  hit_idx;
  logic              drop_f;
  logic              placed;
  logic [IDX_W-1:0]  victim;
  logic [TIME_W-1:0] oldest;

  logic [CNT_W-1:0] n_active;
  logic accept, issue, fire, size_ok, do_store;
  logic match, fresh, is_free, scan_hit, scan_end;

  // Slots beyond the built count are never used
  always_comb begin
    if (32'(cfg.entries_in_use) > 32'(ENTRIES)) begin
      n_active = CNT_W'(ENTRIES);
    end else begin
      n_active = CNT_W'(cfg.entries_in_use);
    end
  end

  assign match = valid[chk_idx] && (mem_rdata.key == req_key);
  assign fresh = match && req_present && (mem_rdata.stamp == req_stamp);
  assign is_free = !valid[chk_idx] || match;
  assign scan_hit = chk_vld && fresh;
  assign scan_end = scan_hit || (!issue && !chk_vld);

  assign size_ok = (cfg.max_pixels == '0) || (cfg.max_pixels >= req_pixels);
  assign do_store = !hit_f && req_load_ok && size_ok && (n_active != '0);

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (accept) st_next = ST_SCAN;
      ST_SCAN: if (scan_end) st_next = ST_DONE;
      ST_DONE: if (fire) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = (st != ST_IDLE);
    issue = (st == ST_SCAN) && (rd_idx < n_active);
    fire = (st == ST_DONE) && (!out_valid || !out_stall);
    mem_we = fire && (hit_f || do_store);
  end

  assign accept = in_valid && !in_stall;
  assign mem_raddr = rd_idx[IDX_W-1:0];
  assign mem_waddr = hit_f ? hit_idx : victim;
  assign mem_wdata = '{key: req_key, stamp: req_stamp, used_at: req_now};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      valid <= '0;
      chk_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      chk_vld <= issue;
      if (st == ST_SCAN && chk_vld && !fresh && match) begin
        valid[chk_idx] <= 1'b0;
      end
      if (fire && do_store) begin
        valid[victim] <= 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_idx[IDX_W-1:0];
    if (accept) begin
      req_key <= key;
      req_stamp <= source_stamp;
      req_present <= source_present;
      req_now <= now;
      req_load_ok <= load_ok;
      req_pixels <= item_pixels;
      rd_idx <= '0;
      hit_f <= 1'b0;
      hit_idx <= '0;
      drop_f <= 1'b0;
      placed <= 1'b0;
      victim <= '0;
      oldest <= now;
    end else if (st == ST_SCAN) begin
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (chk_vld) begin
        if (fresh) begin
          hit_f <= 1'b1;
          hit_idx <= chk_idx;
        end else begin
          if (match) begin
            drop_f <= 1'b1;
          end
          // first free slot wins; otherwise track the oldest use before now
          if (!placed) begin
            if (is_free) begin
              placed <= 1'b1;
              victim <= chk_idx;
            end else if (oldest > mem_rdata.used_at) begin
              oldest <= mem_rdata.used_at;
              victim <= chk_idx;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit <= hit_f;
      stale_dropped <= drop_f;
      stored <= do_store;
      evicted <= do_store && !placed;
      if (hit_f) begin
        slot <= SLOT_W'(hit_idx);
      end else if (do_store) begin
        slot <= SLOT_W'(victim);
      end else begin
        slot <= '0;
      end
    end
  end

`ifndef SYNTH
  a_hit_not_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && stored))
    else $error("hit and stored reported together");

  a_evict_needs_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> stored)
    else $error("eviction without a store");

  a_slot_zero_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit && !stored |-> slot == '0)
    else $error("nonzero slot with neither hit nor store");

  a_write_only_done: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> st == ST_DONE && st_next == ST_IDLE)
    else $error("entry write outside the finishing cycle");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> st == ST_SCAN && !chk_vld && rd_idx == '0)
    else $error("scan did not start cleanly after a transaction");
`endif

endmodule

// File: test/tb.sv
// Self-checking testbench for lru_validated_entry_cache: directed and random requests.
`timescale 1ns / 1ps

import lruc_pkg::*;

typedef struct packed {
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] stamp;
  logic              present;
  logic [TIME_W-1:0] now;
  logic              load_ok;
  logic [PIX_W-1:0]  pixels;
} cache_req_t;

typedef struct packed {
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              dropped;
  logic              stored;
  logic              evicted;
} cache_reply_t;

// Mirror of the cache contents and registers; predicts one reply per request.
class cache_mirror;
  logic [CNT_CFG_W-1:0] entries_cfg;
  logic [PIX_W-1:0]     max_pix_cfg;
  bit                   used[DEF_ENTRIES];
  logic [KEY_W-1:0]     keys[DEF_ENTRIES];
  logic [TIME_W-1:0]    stamps[DEF_ENTRIES];
  logic [TIME_W-1:0]    used_at[DEF_ENTRIES];
  cache_reply_t         expected_replies[$];
  int                   errors;

  function new();
    entries_cfg = RST_ENTRIES;
    max_pix_cfg = RST_MAX_PIX;
    foreach (used[i]) used[i] = 1'b0;
    errors = 0;
  endfunction

  function void apply_reg(logic idx, logic [DATA_W-1:0] data);
    if (idx == REG_ENTRIES) entries_cfg = data[CNT_CFG_W-1:0];
    else max_pix_cfg = data[PIX_W-1:0];
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction

  function void note_request(cache_req_t r);
    cache_reply_t e;
    int n;
    int victim;
    bit placed;
    logic [TIME_W-1:0] oldest;
    e = '0;
    n = (entries_cfg > DEF_ENTRIES) ? DEF_ENTRIES : int'(entries_cfg);
    if (n > 0) begin
      // stale matches ahead of the first fresh one are dropped
      for (int i = 0; i < n; i++) begin
        if (used[i] && keys[i] == r.key) begin
          if (r.present && stamps[i] == r.stamp) begin
            used_at[i] = r.now;
            e.hit = 1'b1;
            e.slot = SLOT_W'(i);
            break;
          end
          used[i] = 1'b0;
          e.dropped = 1'b1;
        end
      end
      if (!e.hit && r.load_ok && (max_pix_cfg == 0 || max_pix_cfg >= r.pixels)) begin
        oldest = r.now;
        victim = 0;
        placed = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!used[i]) begin
            victim = i;
            placed = 1'b1;
            break;
          end
          if (oldest > used_at[i]) begin
            oldest = used_at[i];
            victim = i;
          end
        end
        used[victim] = 1'b1;
        keys[victim] = r.key;
        stamps[victim] = r.stamp;
        used_at[victim] = r.now;
        e.stored = 1'b1;
        e.evicted = !placed;
        e.slot = SLOT_W'(victim);
      end
    end
    expected_replies.push_back(e);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(cache_reply_t got);
    cache_reply_t e;
    if (expected_replies.size() == 0) begin
      $display("%0t: unexpected reply, expected none, got %0h", $time, got);
      errors++;
      return;
    end
    e = expected_replies.pop_front();
    compare_field("hit", e.hit, got.hit);
    compare_field("slot", e.slot, got.slot);
    compare_field("stale_dropped", e.dropped, got.dropped);
    compare_field("stored", e.stored, got.stored);
    compare_field("evicted", e.evicted, got.evicted);
  endfunction
endclass

module tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int KEY_POOL = 16;
  localparam int PHASES = 11;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_PHASE = 4;
  localparam int STEADY_PHASE = 8;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ADDR_W-1:0] ADDR_ENTRIES = {REG_ENTRIES, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_MAX_PIX = {REG_MAX_PIX, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [KEY_W-1:0] key;
  logic [TIME_W-1:0] source_stamp, now;
  logic source_present, load_ok;
  logic [PIX_W-1:0] item_pixels;
  logic hit, stale_dropped, stored, evicted;
  logic [SLOT_W-1:0] slot;

  cache_mirror mirror;
  bit hold_off_req = 1'b0;
  int cycles = 0;
  logic [KEY_W-1:0] key_pool[KEY_POOL];
  logic [TIME_W-1:0] key_stamp[KEY_POOL];
  logic [TIME_W-1:0] wall;
  int unsigned entry_plan[PHASES] = '{8, 4, 15, 1, 8, 0, 9, 2, 8, 7, 8};
  logic [PIX_W-1:0] pix_plan[PHASES] =
    '{24'd4096, 24'd0, 24'hFFFFFF, 24'd4096, 24'd1, 24'd0, 24'd4096, 24'd0, 24'd30000,
      24'd4096, 24'd0};

  lru_validated_entry_cache i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .key(key), .source_stamp(source_stamp), .source_present(source_present), .now(now),
    .load_ok(load_ok), .item_pixels(item_pixels),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .slot(slot), .stale_dropped(stale_dropped), .stored(stored),
    .evicted(evicted)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lru_validated_entry_cache regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      mirror.check_reply({hit, slot, stale_dropped, stored, evicted});
  end

  // result backpressure: random windows, plus one long hold when requested
  initial begin : result_backpressure
    int mode;
    int span;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 60);
        repeat (span) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic offer(cache_req_t r);
    key <= r.key;
    source_stamp <= r.stamp;
    source_present <= r.present;
    now <= r.now;
    load_ok <= r.load_ok;
    item_pixels <= r.pixels;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_request(r);
  endtask

  task automatic send(logic [KEY_W-1:0] k, logic [TIME_W-1:0] st, logic pr,
                      logic [TIME_W-1:0] t, logic ok, logic [PIX_W-1:0] px);
    offer('{key: k, stamp: st, present: pr, now: t, load_ok: ok, pixels: px});
  endtask

  task automatic apb_access(input logic [ADDR_W-1:0] addr, input logic write,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  // waits for the cache to go quiet, writes a register and reads it back
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] junk;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] readback;
    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    junk = $urandom;
    if (addr == ADDR_ENTRIES) data = {junk[DATA_W-1:CNT_CFG_W], value[CNT_CFG_W-1:0]};
    else data = {junk[DATA_W-1:PIX_W], value[PIX_W-1:0]};
    apb_access(addr, 1'b1, data, readback);
    mirror.apply_reg(addr[2], data);
    apb_access(addr, 1'b0, '0, readback);
    psel <= 1'b0;
    penable <= 1'b0;
    want = (addr == ADDR_ENTRIES) ? DATA_W'(mirror.entries_cfg) : DATA_W'(mirror.max_pix_cfg);
    if (readback !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
               $time, addr, want, readback);
      mirror.errors++;
    end
  endtask

  // mostly repeat lookups over a small key set with an advancing clock; some noise
  function automatic cache_req_t make_request();
    cache_req_t r;
    int k;
    k = $urandom_range(0, KEY_POOL - 1);
    if ($urandom_range(0, 9) == 0) key_stamp[k] = $urandom;
    r.key = ($urandom_range(0, 19) == 0) ? KEY_W'($urandom) : key_pool[k];
    r.stamp = key_stamp[k];
    r.present = ($urandom_range(0, 11) != 0);
    if ($urandom_range(0, 24) == 0) begin
      r.now = $urandom;
    end else begin
      wall = wall + $urandom_range(0, 2);
      r.now = wall;
    end
    r.load_ok = ($urandom_range(0, 6) != 0);
    case ($urandom_range(0, 9))
      0: r.pixels = PIX_W'($urandom);
      1: r.pixels = mirror.max_pix_cfg + 1'b1;
      2: r.pixels = mirror.max_pix_cfg;
      default: r.pixels = (mirror.max_pix_cfg == 0) ? PIX_W'($urandom_range(0, 5000))
                                                    : PIX_W'($urandom_range(0, mirror.max_pix_cfg));
    endcase
    return r;
  endfunction

  task automatic run_phase(int count, bit steady);
    int burst;
    burst = $urandom_range(1, 12);
    repeat (count) begin
      offer(make_request());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (!steady && $urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 25)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin : stimulus
    mirror = new();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    key <= '0;
    source_stamp <= '0;
    source_present <= 1'b0;
    now <= '0;
    load_ok <= 1'b0;
    item_pixels <= '0;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      key_stamp[i] = $urandom;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    wall = $urandom_range(1000, 1 << 30);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(32'd0, 32'd0, 1'b1, 32'd0, 1'b1, 24'd0);
    send(32'd0, 32'd0, 1'b1, 32'd5, 1'b1, 24'd0);
    send(32'd0, 32'd1, 1'b1, 32'd6, 1'b0, 24'd0);           // stale, nothing loaded
    send('1, '1, 1'b1, '1, 1'b1, 24'd4096);                  // size exactly at limit
    send(32'd1, 32'd7, 1'b1, 32'd7, 1'b1, 24'd4097);         // one over the limit
    send('1, '1, 1'b0, 32'd8, 1'b0, 24'd0);                  // source gone
    for (int i = 0; i < DEF_ENTRIES; i++)
      send(32'd100 + i, 32'd50 + i, 1'b1, 32'd20 + i, 1'b1, 24'd64);
    send(32'd200, 32'd3, 1'b1, 32'd40, 1'b1, 24'd10);        // LRU eviction
    send(32'd201, 32'd3, 1'b1, 32'd0, 1'b1, 24'd10);         // nothing older, falls to slot 0
    send(32'd105, 32'd55, 1'b1, 32'd41, 1'b1, '1);
    write_reg(ADDR_ENTRIES, 0);
    send(32'd105, 32'd55, 1'b1, 32'd42, 1'b1, 24'd0);        // cache off
    write_reg(ADDR_ENTRIES, 15);
    write_reg(ADDR_MAX_PIX, 0);
    send(32'd300, 32'd9, 1'b1, 32'd50, 1'b1, '1);
    // shrink, refill a key held in a hidden slot, then expose both copies
    write_reg(ADDR_ENTRIES, 2);
    send(32'd106, 32'd999, 1'b1, 32'd60, 1'b1, 24'd5);
    write_reg(ADDR_ENTRIES, 8);
    send(32'd106, 32'd56, 1'b1, 32'd61, 1'b0, 24'd0);
    send(32'd2, 32'd2, 1'b0, 32'd62, 1'b1, 24'd0);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(ADDR_ENTRIES, entry_plan[p]);
      write_reg(ADDR_MAX_PIX, pix_plan[p]);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      run_phase(ITEMS_PER_PHASE, p == HOLD_PHASE || p == STEADY_PHASE);
    end

    in_valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mirror.errors == 0)
      $display("lru_validated_entry_cache regression: pass");
    else
      $display("lru_validated_entry_cache regression: fail");
    $finish;
  end

endmodule
